// ----- hdl/cmr_pkg.sv -----
// Shared types, codes and constants of the CTAPHID message reassembler.
// Used by cmr_front, cmr_back and ctaphid_message_reassembler.
package cmr_pkg;

   localparam int REPORT_BYTES      = 64;
   localparam int POS_WIDTH         = $clog2(REPORT_BYTES);
   localparam int QUEUE_DEPTH_DFLT  = 2;

   localparam int TICKS_WIDTH       = 16;
   localparam int LEN_WIDTH         = 13;
   localparam int CID_WIDTH         = 32;
   localparam int CMD_WIDTH         = 7;

   localparam logic [TICKS_WIDTH-1:0] TIMEOUT_RESET = 16'd3000;
   localparam logic [LEN_WIDTH-1:0]   MAX_LEN_RESET = 13'd7609;

   localparam logic [POS_WIDTH-1:0] POS_CMD     = POS_WIDTH'(4);
   localparam logic [POS_WIDTH-1:0] POS_LEN_HI  = POS_WIDTH'(5);
   localparam logic [POS_WIDTH-1:0] POS_LEN_LO  = POS_WIDTH'(6);
   localparam logic [POS_WIDTH-1:0] POS_LAST    = POS_WIDTH'(REPORT_BYTES - 1);

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_MSG_LEN   = 2'd1;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_INIT    = 2'd1,
      MODE_CONT    = 2'd2,
      MODE_DISCARD = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_INVALID_LEN = 2'd0,
      ERR_INVALID_SEQ = 2'd1,
      ERR_TIMEOUT     = 2'd2
   } err_type;

   // Classified item as it travels through the queue.
   typedef struct packed {
      logic                 is_tick;
      logic [POS_WIDTH-1:0] pos;
      logic [7:0]           data;
   } item_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           payload_byte;
      logic [LEN_WIDTH-1:0] byte_offset;
      logic [CID_WIDTH-1:0] msg_cid;
      logic [CMD_WIDTH-1:0] msg_cmd;
      logic [LEN_WIDTH-1:0] msg_length;
      logic                 msg_last;
      err_type              error_code;
   } result_type;

endpackage

// ----- hdl/cmr_front.sv -----
// Front end: accepts report bytes and ticks, tags each byte with its place
// in the report and queues the classified item. Depends on cmr_pkg.
module cmr_front
   import cmr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  logic     in_type,
   input  logic [7:0] in_data,
   output logic     item_valid,
   input  logic     item_ready,
   output item_type item
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);

   item_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 push, pop;
   item_type             new_item;

   assign in_ready   = (count_ff != CNT_FULL);
   assign push       = in_valid & in_ready;
   assign item_valid = (count_ff != '0);
   assign pop        = item_valid & item_ready;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.is_tick = (in_type == REQ_TICK);
      new_item.pos     = pos_ff;
      new_item.data    = in_data;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         // advance the report position on bytes only; it wraps at the report end
         if (in_type == REQ_BYTE) begin
            pos_in = pos_ff + 1'b1;
         end
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- hdl/cmr_back.sv -----
// Back end: runs the packet header decoder and message tracker on queued
// items and holds one result in an output register. Depends on cmr_pkg.
module cmr_back
   import cmr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  item_type               item,
   input  logic [TICKS_WIDTH-1:0] timeout_ticks,
   input  logic [LEN_WIDTH-1:0]   max_msg_len,
   output logic                   out_valid,
   input  logic                   out_ready,
   output result_type             out_result
);

   mode_type             mode_ff, mode_in;
   logic [CID_WIDTH-1:0] header_cid_ff, header_cid_in;
   logic [7:0]           len_hi_ff, len_hi_in;
   logic                 receiving_ff, receiving_in;
   logic [CID_WIDTH-1:0] active_cid_ff, active_cid_in;
   logic [CMD_WIDTH-1:0] active_cmd_ff, active_cmd_in;
   logic [LEN_WIDTH-1:0] active_len_ff, active_len_in;
   logic [LEN_WIDTH-1:0] received_ff, received_in;
   logic [7:0]           exp_seq_ff, exp_seq_in;
   logic [TICKS_WIDTH-1:0] idle_ff, idle_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           result_ff, result_in;

   logic                 fire;
   logic                 produce;
   logic [15:0]          total;
   logic                 is_cmd, is_len_hi, is_len_lo, in_body;

   assign item_ready = !out_valid_ff || out_ready;
   assign fire       = item_valid & item_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   assign total     = {len_hi_ff, item.data};
   assign is_cmd    = (item.pos == POS_CMD);
   assign is_len_hi = (mode_ff == MODE_INIT) && (item.pos == POS_LEN_HI);
   assign is_len_lo = (mode_ff == MODE_INIT) && (item.pos == POS_LEN_LO);
   assign in_body   = (mode_ff == MODE_INIT) || (mode_ff == MODE_CONT);

   // next packet mode
   always_comb begin
      mode_in = mode_ff;
      if (fire && !item.is_tick) begin
         if (item.pos < POS_CMD) begin
            mode_in = MODE_HEADER;
         end else if (is_cmd) begin
            if (item.data[7]) begin
               mode_in = MODE_INIT;
            end else if (!receiving_ff || header_cid_ff != active_cid_ff) begin
               mode_in = MODE_DISCARD;
            end else if (item.data != exp_seq_ff) begin
               mode_in = MODE_DISCARD;
            end else begin
               mode_in = MODE_CONT;
            end
         end else if (is_len_lo) begin
            if (total > {3'b000, max_msg_len} || total == '0) begin
               mode_in = MODE_DISCARD;
            end
         end
         if (item.pos == POS_LAST) begin
            mode_in = MODE_HEADER;
         end
      end
   end

   // message state and result
   always_comb begin
      header_cid_in = header_cid_ff;
      len_hi_in     = len_hi_ff;
      receiving_in  = receiving_ff;
      active_cid_in = active_cid_ff;
      active_cmd_in = active_cmd_ff;
      active_len_in = active_len_ff;
      received_in   = received_ff;
      exp_seq_in    = exp_seq_ff;
      idle_in       = idle_ff;
      produce       = 1'b0;
      result_in     = '0;
      if (fire) begin
         if (item.is_tick) begin
            if (receiving_ff) begin
               if (idle_ff >= timeout_ticks) begin
                  produce              = 1'b1;
                  result_in.kind       = KIND_ERROR;
                  result_in.msg_cid    = active_cid_ff;
                  result_in.error_code = ERR_TIMEOUT;
                  receiving_in         = 1'b0;
               end else begin
                  idle_in = idle_ff + 1'b1;
               end
            end
         end else if (item.pos < POS_CMD) begin
            header_cid_in = {header_cid_ff[CID_WIDTH-9:0], item.data};
         end else if (is_cmd) begin
            if (item.data[7]) begin
               active_cmd_in = item.data[CMD_WIDTH-1:0];
            end else if (!receiving_ff || header_cid_ff != active_cid_ff) begin
               // foreign or stray continuation: drop it
            end else if (item.data != exp_seq_ff) begin
               produce              = 1'b1;
               result_in.kind       = KIND_ERROR;
               result_in.msg_cid    = header_cid_ff;
               result_in.error_code = ERR_INVALID_SEQ;
               receiving_in         = 1'b0;
            end else begin
               exp_seq_in = exp_seq_ff + 1'b1;
               idle_in    = '0;
            end
         end else if (is_len_hi) begin
            len_hi_in = item.data;
         end else if (is_len_lo) begin
            if (total > {3'b000, max_msg_len}) begin
               produce              = 1'b1;
               result_in.kind       = KIND_ERROR;
               result_in.msg_cid    = header_cid_ff;
               result_in.error_code = ERR_INVALID_LEN;
               receiving_in         = 1'b0;
            end else begin
               active_cid_in = header_cid_ff;
               active_len_in = total[LEN_WIDTH-1:0];
               received_in   = '0;
               exp_seq_in    = '0;
               idle_in       = '0;
               if (total == '0) begin
                  produce            = 1'b1;
                  result_in.kind     = KIND_EMPTY;
                  result_in.msg_cid  = header_cid_ff;
                  result_in.msg_cmd  = active_cmd_ff;
                  result_in.msg_last = 1'b1;
                  receiving_in       = 1'b0;
               end else begin
                  receiving_in = 1'b1;
               end
            end
         end else if (in_body && receiving_ff && received_ff < active_len_ff) begin
            produce                = 1'b1;
            result_in.kind         = KIND_PAYLOAD;
            result_in.payload_byte = item.data;
            result_in.byte_offset  = received_ff;
            result_in.msg_cid      = active_cid_ff;
            result_in.msg_cmd      = active_cmd_ff;
            result_in.msg_length   = active_len_ff;
            result_in.msg_last     = (received_ff + 1'b1 == active_len_ff);
            received_in            = received_ff + 1'b1;
            if (result_in.msg_last) begin
               receiving_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = produce;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_HEADER;
         header_cid_ff <= '0;
         len_hi_ff     <= '0;
         receiving_ff  <= 1'b0;
         active_cid_ff <= '0;
         active_cmd_ff <= '0;
         active_len_ff <= '0;
         received_ff   <= '0;
         exp_seq_ff    <= '0;
         idle_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         header_cid_ff <= header_cid_in;
         len_hi_ff     <= len_hi_in;
         receiving_ff  <= receiving_in;
         active_cid_ff <= active_cid_in;
         active_cmd_ff <= active_cmd_in;
         active_len_ff <= active_len_in;
         received_ff   <= received_in;
         exp_seq_ff    <= exp_seq_in;
         idle_ff       <= idle_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && produce) begin
         result_ff <= result_in;
      end
   end

   a_payload_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.kind == KIND_PAYLOAD
         |-> result_ff.byte_offset < result_ff.msg_length)
      else $error("payload offset beyond announced length");

   a_receiving_has_room: assert property (@(posedge clock) disable iff (reset)
      receiving_ff |-> received_ff < active_len_ff)
      else $error("receiving with message already complete");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.kind == KIND_ERROR
         |-> !result_ff.msg_last && result_ff.msg_cmd == '0)
      else $error("error result carries message fields");

   a_last_ends_message: assert property (@(posedge clock) disable iff (reset)
      fire && produce && result_in.msg_last |=> !receiving_ff)
      else $error("message still open after its last byte");

endmodule

// ----- hdl/ctaphid_message_reassembler.sv -----
// CTAPHID message reassembler: report bytes and ticks in; payload, empty and
// error results out. cmr_front queues each accepted item and cmr_back
// registers its result. Throughput: one item per cycle while results drain.
// Reset (synchronous, active high) empties the queue, returns to idle and
// loads timeout_ticks = 3000, max_msg_len = 7609. Depends on cmr_pkg.
module ctaphid_message_reassembler
   import cmr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] req_type
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [20:8] byte_offset, [52:21] msg_cid, [59:53] msg_cmd,
   // [72:60] msg_length, [74:73] error_code, [79:75] zero
   output logic [79:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // msg_last
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0] csr_data
);

   logic [TICKS_WIDTH-1:0] timeout_ff;
   logic [LEN_WIDTH-1:0]   max_len_ff;
   logic                   item_valid, item_ready;
   item_type               item;
   result_type             result;

   // The user must write only while idle; the block does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS: timeout_ff <= csr_data;
            CSR_MAX_MSG_LEN:   max_len_ff <= csr_data[LEN_WIDTH-1:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // Front: classify and queue items.
   cmr_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_type    (req_tuser),
      .in_data    (req_tdata),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // Back: decode headers, track the message, hold the result transaction.
   cmr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item),
      .timeout_ticks (timeout_ff),
      .max_msg_len   (max_len_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_result    (result)
   );

   assign rsp_tdata = {5'b00000, result.error_code, result.msg_length, result.msg_cmd,
                       result.msg_cid, result.byte_offset, result.payload_byte};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.msg_last;

endmodule
